// ===== hdl/tbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants for the battery thermal charge controller
// Temperature bands, charging modes, transition codes, register map, resets.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int unsigned TempW = 8;
	localparam int unsigned VoltW = 23;
	localparam int unsigned CurW  = 12;

	typedef logic signed [TempW-1:0] temp_t;
	typedef logic [VoltW-1:0]        volt_t;
	typedef logic [CurW-1:0]         cur_t;

	// temperature bands, coldest first
	typedef enum logic [2:0] {
		BAND_FROZEN = 3'd0,  // <= -11
		BAND_COLD   = 3'd1,  // -10 .. -5
		BAND_NORMAL = 3'd2,  // -4 .. 41
		BAND_WARM   = 3'd3,  // 42 .. 45
		BAND_HOT    = 3'd4,  // 46 .. 52
		BAND_VHOT   = 3'd5,  // 53 .. 55
		BAND_OVER   = 3'd6   // >= 56
	} band_t;

	// upper edges of the bands
	localparam temp_t EdgeFrozen = -8'sd11;
	localparam temp_t EdgeCold   = -8'sd5;
	localparam temp_t EdgeNormal = 8'sd41;
	localparam temp_t EdgeWarm   = 8'sd45;
	localparam temp_t EdgeHot    = 8'sd52;
	localparam temp_t EdgeVhot   = 8'sd55;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_REDUCED = 2'd1,
		MODE_STOPPED = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		CODE_NONE        = 3'd0,
		CODE_NORM_TO_RED = 3'd1,
		CODE_NORM_TO_STP = 3'd2,
		CODE_RED_TO_NORM = 3'd3,
		CODE_RED_TO_STP  = 3'd4,
		CODE_STP_TO_NORM = 3'd5,
		CODE_STP_TO_RED  = 3'd6
	} code_t;

	typedef enum logic [1:0] {
		HEALTH_GOOD = 2'd0,
		HEALTH_HOT  = 2'd1,
		HEALTH_COLD = 2'd2
	} health_t;

	// register map
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_VOLT_LIMIT  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_REDUCED_CUR = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_DEFAULT_CUR = 2'd2;

	localparam volt_t RstVoltLimit  = 23'd4000000;
	localparam cur_t  RstReducedCur = 12'd450;
	localparam cur_t  RstDefaultCur = 12'd1500;

	// machine state carried from item to item
	typedef struct packed {
		mode_t mode;
		logic  last_charger;
		logic  indicator;
		cur_t  last_current;
	} tbc_state_t;

	// one result transaction
	typedef struct packed {
		mode_t   charge_state;
		code_t   code;
		logic    update_req;
		logic    charge_disable;
		cur_t    drive_current;
		health_t health;
		logic    pseudo_charging;
	} tbc_result_t;

endpackage

// ===== hdl/tbc_band.sv =====
// ----------------------------------------------------------------------------
// tbc_band: temperature band classifier
// Sorts a signed temperature into the seven fixed bands.
// ----------------------------------------------------------------------------
module tbc_band (
	input  tbc_pkg::temp_t temp,
	output tbc_pkg::band_t band
);

	always_comb begin
		priority if (temp <= tbc_pkg::EdgeFrozen) begin
			band = tbc_pkg::BAND_FROZEN;
		end else if (temp <= tbc_pkg::EdgeCold) begin
			band = tbc_pkg::BAND_COLD;
		end else if (temp <= tbc_pkg::EdgeNormal) begin
			band = tbc_pkg::BAND_NORMAL;
		end else if (temp <= tbc_pkg::EdgeWarm) begin
			band = tbc_pkg::BAND_WARM;
		end else if (temp <= tbc_pkg::EdgeHot) begin
			band = tbc_pkg::BAND_HOT;
		end else if (temp <= tbc_pkg::EdgeVhot) begin
			band = tbc_pkg::BAND_VHOT;
		end else begin
			band = tbc_pkg::BAND_OVER;
		end
	end

endmodule

// ===== hdl/tbc_step.sv =====
// ----------------------------------------------------------------------------
// tbc_step: charging state machine step
// Next state and result for one sample, from the band and the current state.
// ----------------------------------------------------------------------------
module tbc_step (
	input  tbc_pkg::tbc_state_t  cur_state,
	input  tbc_pkg::band_t       band,
	input  logic                 high_v,
	input  logic                 charger_present,
	input  logic                 charger_swapped,
	input  tbc_pkg::cur_t        normal_limit,
	input  tbc_pkg::cur_t        thermal_limit,
	input  tbc_pkg::cur_t        reduced_cur,
	input  tbc_pkg::cur_t        default_cur,
	output tbc_pkg::tbc_state_t  nxt_state,
	output tbc_pkg::tbc_result_t result
);

	logic            attach;
	logic            extreme;
	logic            ind_nxt;
	tbc_pkg::mode_t  mode_in;
	tbc_pkg::mode_t  mode_nxt;
	tbc_pkg::code_t  code;
	tbc_pkg::cur_t   cur;
	tbc_pkg::health_t health;

	// new charger (edge or swap with charger present) restarts in normal
	assign attach  = ((cur_state.last_charger != charger_present) || charger_swapped)
		&& charger_present;
	assign mode_in = attach ? tbc_pkg::MODE_NORMAL : cur_state.mode;
	assign extreme = (band == tbc_pkg::BAND_OVER) || (band == tbc_pkg::BAND_FROZEN);

	always_comb begin
		mode_nxt = mode_in;
		code     = tbc_pkg::CODE_NONE;
		ind_nxt  = cur_state.indicator;
		unique case (mode_in)
			tbc_pkg::MODE_NORMAL: begin
				if (extreme) begin
					code = tbc_pkg::CODE_NORM_TO_STP; ind_nxt = 1'b0;
					mode_nxt = tbc_pkg::MODE_STOPPED;
				end else if (band == tbc_pkg::BAND_HOT || band == tbc_pkg::BAND_VHOT) begin
					if (high_v) begin
						code = tbc_pkg::CODE_NORM_TO_STP; ind_nxt = 1'b1;
						mode_nxt = tbc_pkg::MODE_STOPPED;
					end else begin
						code = tbc_pkg::CODE_NORM_TO_RED; ind_nxt = 1'b0;
						mode_nxt = tbc_pkg::MODE_REDUCED;
					end
				end
			end
			tbc_pkg::MODE_REDUCED: begin
				if (extreme || high_v) begin
					code = tbc_pkg::CODE_RED_TO_STP; ind_nxt = !extreme;
					mode_nxt = tbc_pkg::MODE_STOPPED;
				end else if (band <= tbc_pkg::BAND_NORMAL) begin
					code = tbc_pkg::CODE_RED_TO_NORM; ind_nxt = 1'b0;
					mode_nxt = tbc_pkg::MODE_NORMAL;
				end
			end
			tbc_pkg::MODE_STOPPED: begin
				if (band == tbc_pkg::BAND_NORMAL) begin
					code = tbc_pkg::CODE_STP_TO_NORM; ind_nxt = 1'b0;
					mode_nxt = tbc_pkg::MODE_NORMAL;
				end else if (band == tbc_pkg::BAND_WARM || band == tbc_pkg::BAND_HOT) begin
					if (high_v) begin
						ind_nxt = 1'b1;
					end else begin
						code = tbc_pkg::CODE_STP_TO_RED; ind_nxt = 1'b0;
						mode_nxt = tbc_pkg::MODE_REDUCED;
					end
				end else if (band == tbc_pkg::BAND_OVER) begin
					ind_nxt = 1'b0;
				end
			end
			default: begin
				// unused code: held, no transition
			end
		endcase
	end

	always_comb begin
		unique case (mode_nxt)
			tbc_pkg::MODE_NORMAL:
				cur = (thermal_limit <= normal_limit) ? thermal_limit : normal_limit;
			tbc_pkg::MODE_REDUCED:
				cur = (thermal_limit <= reduced_cur) ? thermal_limit : reduced_cur;
			default:
				cur = default_cur;
		endcase
	end

	always_comb begin
		unique case (band)
			tbc_pkg::BAND_OVER:   health = tbc_pkg::HEALTH_HOT;
			tbc_pkg::BAND_FROZEN: health = tbc_pkg::HEALTH_COLD;
			default:              health = tbc_pkg::HEALTH_GOOD;
		endcase
	end

	always_comb begin
		nxt_state.mode         = mode_nxt;
		nxt_state.last_charger = charger_present;
		nxt_state.indicator    = ind_nxt;
		nxt_state.last_current = cur;

		result.charge_state    = mode_nxt;
		result.code            = code;
		result.update_req      = attach || (cur != cur_state.last_current)
			|| (ind_nxt != cur_state.indicator);
		result.charge_disable  = (mode_nxt == tbc_pkg::MODE_STOPPED);
		result.drive_current   = cur;
		result.health          = health;
		result.pseudo_charging = ind_nxt;
	end

endmodule

// ===== hdl/battery_thermal_charge_controller_core.sv =====
// ----------------------------------------------------------------------------
// battery_thermal_charge_controller_core: temperature-banded charge control
// Sample in, one result out; three-state charging machine with thermal bands.
// ----------------------------------------------------------------------------
// Pipeline: a taken sample is registered in stage 1; its result is then loaded into
//   the output register once that register is free or draining.
// Throughput: one sample per cycle unless out_ready stalls; single state register.
// Reset (arst_n low, asynchronous): mode normal, charger/indicator/current
//   history cleared, registers at their defaults, both stages empty.
module battery_thermal_charge_controller_core (
	input  logic        clk,
	input  logic        arst_n,

	// sample channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  battery_temp,
	input  logic [22:0] battery_uv,
	input  logic        charger_present,
	input  logic        charger_swapped,
	input  logic [11:0] normal_limit_ma,
	input  logic [11:0] thermal_limit_ma,

	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  charge_state,
	output logic [2:0]  transition_code,
	output logic        update_req,
	output logic        charge_disable,
	output logic [11:0] drive_current_ma,
	output logic [1:0]  health,
	output logic        pseudo_charging,

	// register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	// configuration registers
	tbc_pkg::volt_t voltage_limit_q;
	tbc_pkg::cur_t  reduced_cur_q;
	tbc_pkg::cur_t  default_cur_q;

	// input stage
	logic            valid_s1;
	tbc_pkg::temp_t  temp_s1;
	tbc_pkg::volt_t  volt_s1;
	logic            present_s1;
	logic            swapped_s1;
	tbc_pkg::cur_t   normal_s1;
	tbc_pkg::cur_t   thermal_s1;

	// machine state and output register
	tbc_pkg::tbc_state_t  state_q;
	tbc_pkg::tbc_state_t  state_nxt;
	tbc_pkg::tbc_result_t res_nxt;
	tbc_pkg::tbc_result_t res_q;
	logic                 out_valid_q;

	tbc_pkg::band_t band;
	logic           high_v;
	logic           advance;

	// the stage-1 sample moves on when the output register is free or draining
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_limit_q <= tbc_pkg::RstVoltLimit;
			reduced_cur_q   <= tbc_pkg::RstReducedCur;
			default_cur_q   <= tbc_pkg::RstDefaultCur;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tbc_pkg::REG_VOLT_LIMIT:  voltage_limit_q <= cfg_data;
				tbc_pkg::REG_REDUCED_CUR: reduced_cur_q   <= cfg_data[11:0];
				tbc_pkg::REG_DEFAULT_CUR: default_cur_q   <= cfg_data[11:0];
				default: ;  // unmapped index: dropped
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// sample payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			temp_s1    <= battery_temp;
			volt_s1    <= battery_uv;
			present_s1 <= charger_present;
			swapped_s1 <= charger_swapped;
			normal_s1  <= normal_limit_ma;
			thermal_s1 <= thermal_limit_ma;
		end
	end

	tbc_band u_band (
		.temp (temp_s1),
		.band (band)
	);

	// equal to the limit does not count as high
	assign high_v = volt_s1 > voltage_limit_q;

	tbc_step u_step (
		.cur_state       (state_q),
		.band            (band),
		.high_v          (high_v),
		.charger_present (present_s1),
		.charger_swapped (swapped_s1),
		.normal_limit    (normal_s1),
		.thermal_limit   (thermal_s1),
		.reduced_cur     (reduced_cur_q),
		.default_cur     (default_cur_q),
		.nxt_state       (state_nxt),
		.result          (res_nxt)
	);

	// state commits with the transaction that leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode         <= tbc_pkg::MODE_NORMAL;
			state_q.last_charger <= 1'b0;
			state_q.indicator    <= 1'b0;
			state_q.last_current <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign charge_state     = res_q.charge_state;
	assign transition_code  = res_q.code;
	assign update_req       = res_q.update_req;
	assign charge_disable   = res_q.charge_disable;
	assign drive_current_ma = res_q.drive_current;
	assign health           = res_q.health;
	assign pseudo_charging  = res_q.pseudo_charging;

endmodule

// ===== hdl/tbc_checker.sv =====
// ----------------------------------------------------------------------------
// tbc_checker: port-level checks for the charge controller
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module tbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  charge_state,
	input logic [2:0]  transition_code,
	input logic        charge_disable,
	input logic [11:0] drive_current_ma,
	input logic [1:0]  health
);

	// no result shows on the edge after one seen in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(charge_state)
			&& $stable(drive_current_ma))
		else $error("stalled result changed");

	// disable flag matches the stopped state
	a_disable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (charge_disable == (charge_state == tbc_pkg::MODE_STOPPED)))
		else $error("charge_disable disagrees with state");

	// transitions into stopped land in stopped
	a_to_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (transition_code == tbc_pkg::CODE_NORM_TO_STP
			|| transition_code == tbc_pkg::CODE_RED_TO_STP)
		|-> charge_state == tbc_pkg::MODE_STOPPED)
		else $error("stop transition without stopped state");

	// too hot or too cold always ends stopped
	a_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && health != tbc_pkg::HEALTH_GOOD |-> charge_disable)
		else $error("charging while overheated or cold");

endmodule

bind battery_thermal_charge_controller_core tbc_checker u_tbc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.charge_state     (charge_state),
	.transition_code  (transition_code),
	.charge_disable   (charge_disable),
	.drive_current_ma (drive_current_ma),
	.health           (health)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for battery_thermal_charge_controller_core
// Drives monitoring samples and register writes over valid/ready, predicts
// each result with a local copy of the banded charging machine and compares
// every result transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb;

	// index outside the register map, the write must leave everything as is
	localparam logic [tbc_pkg::CfgIdxW-1:0] RegSpare = 2'd3;
	localparam int unsigned GapMax      = 17;
	localparam int unsigned DrainCycles = 4;   // idle margin after every result is back
	localparam int unsigned RandPerPhase = 100;
	localparam int unsigned NumPhases    = 6;
	localparam int          VoltMax      = 8388607;

	typedef struct packed {
		tbc_pkg::temp_t temp;
		tbc_pkg::volt_t uv;
		logic           present;
		logic           swapped;
		tbc_pkg::cur_t  normal_ma;
		tbc_pkg::cur_t  thermal_ma;
	} sample_t;

	typedef struct packed {
		logic [tbc_pkg::CfgIdxW-1:0] idx;
		tbc_pkg::volt_t              data;
	} reg_write_t;

	// ------------------------------------------------------------------
	// DUT connections; every input starts at a known value
	// ------------------------------------------------------------------
	logic        clk              = 1'b0;
	logic        arst_n           = 1'b0;
	logic        in_valid         = 1'b0;
	logic        in_ready;
	logic [7:0]  battery_temp     = '0;
	logic [22:0] battery_uv       = '0;
	logic        charger_present  = 1'b0;
	logic        charger_swapped  = 1'b0;
	logic [11:0] normal_limit_ma  = '0;
	logic [11:0] thermal_limit_ma = '0;
	logic        out_valid;
	logic        out_ready        = 1'b0;
	logic [1:0]  charge_state;
	logic [2:0]  transition_code;
	logic        update_req;
	logic        charge_disable;
	logic [11:0] drive_current_ma;
	logic [1:0]  health;
	logic        pseudo_charging;
	logic        cfg_valid        = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index        = '0;
	logic [22:0] cfg_data         = '0;

	battery_thermal_charge_controller_core i_dut (.*);

	// ------------------------------------------------------------------
	// Predictor: register copies and machine state, as after reset
	// ------------------------------------------------------------------
	tbc_pkg::volt_t reg_volt_limit  = tbc_pkg::RstVoltLimit;
	tbc_pkg::cur_t  reg_reduced_cur = tbc_pkg::RstReducedCur;
	tbc_pkg::cur_t  reg_default_cur = tbc_pkg::RstDefaultCur;

	tbc_pkg::mode_t exp_mode      = tbc_pkg::MODE_NORMAL;
	logic  exp_last_charger       = 1'b0;
	logic  exp_indicator          = 1'b0;
	logic  exp_last_indicator     = 1'b0;
	tbc_pkg::cur_t exp_last_current = '0;

	sample_t              sample_q[$];
	reg_write_t           reg_write_q[$];
	tbc_pkg::tbc_result_t predicted_results[$];

	// sent/taken counters let the sequencer see when the block is drained
	// without racing the drivers on queue pops
	int unsigned samples_sent = 0;
	int unsigned samples_taken = 0;
	int unsigned writes_sent = 0;
	int unsigned writes_taken = 0;
	int          mismatches = 0;

	int unsigned in_gap = 0;
	int unsigned out_stall = 0;
	bit          no_idle = 1'b0;
	sample_t     cur_sample;

	tbc_pkg::temp_t band_tops [6] = '{tbc_pkg::EdgeFrozen, tbc_pkg::EdgeCold,
		tbc_pkg::EdgeNormal, tbc_pkg::EdgeWarm, tbc_pkg::EdgeHot, tbc_pkg::EdgeVhot};

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic tbc_pkg::band_t band_of(tbc_pkg::temp_t t);
		if (t <= tbc_pkg::EdgeFrozen) return tbc_pkg::BAND_FROZEN;
		if (t <= tbc_pkg::EdgeCold)   return tbc_pkg::BAND_COLD;
		if (t <= tbc_pkg::EdgeNormal) return tbc_pkg::BAND_NORMAL;
		if (t <= tbc_pkg::EdgeWarm)   return tbc_pkg::BAND_WARM;
		if (t <= tbc_pkg::EdgeHot)    return tbc_pkg::BAND_HOT;
		if (t <= tbc_pkg::EdgeVhot)   return tbc_pkg::BAND_VHOT;
		return tbc_pkg::BAND_OVER;
	endfunction

	// One sample through the charging machine; updates the predictor state.
	function automatic tbc_pkg::tbc_result_t charge_step(sample_t s);
		tbc_pkg::tbc_result_t r;
		tbc_pkg::band_t       b;
		logic                 high_v;
		logic                 extreme;
		logic                 upd;
		tbc_pkg::mode_t       nxt;
		tbc_pkg::code_t       code;
		tbc_pkg::cur_t        cur;
		upd  = 1'b0;
		code = tbc_pkg::CODE_NONE;
		// charger edge or software swap; attaching restarts normal charging
		if (exp_last_charger != s.present || s.swapped) begin
			exp_last_charger = s.present;
			if (s.present) begin
				exp_mode = tbc_pkg::MODE_NORMAL;
				upd      = 1'b1;
			end
		end
		b       = band_of(s.temp);
		high_v  = s.uv > reg_volt_limit;   // equal is not above
		extreme = (b == tbc_pkg::BAND_OVER) || (b == tbc_pkg::BAND_FROZEN);
		nxt     = exp_mode;
		case (exp_mode)
			tbc_pkg::MODE_NORMAL: begin
				if (extreme) begin
					code = tbc_pkg::CODE_NORM_TO_STP; exp_indicator = 1'b0;
					nxt = tbc_pkg::MODE_STOPPED;
				end else if (b == tbc_pkg::BAND_HOT || b == tbc_pkg::BAND_VHOT) begin
					if (high_v) begin
						code = tbc_pkg::CODE_NORM_TO_STP; exp_indicator = 1'b1;
						nxt = tbc_pkg::MODE_STOPPED;
					end else begin
						code = tbc_pkg::CODE_NORM_TO_RED; exp_indicator = 1'b0;
						nxt = tbc_pkg::MODE_REDUCED;
					end
				end
			end
			tbc_pkg::MODE_REDUCED: begin
				if (extreme) begin
					code = tbc_pkg::CODE_RED_TO_STP; exp_indicator = 1'b0;
					nxt = tbc_pkg::MODE_STOPPED;
				end else if (high_v) begin
					code = tbc_pkg::CODE_RED_TO_STP; exp_indicator = 1'b1;
					nxt = tbc_pkg::MODE_STOPPED;
				end else if (b <= tbc_pkg::BAND_NORMAL) begin
					code = tbc_pkg::CODE_RED_TO_NORM; exp_indicator = 1'b0;
					nxt = tbc_pkg::MODE_NORMAL;
				end
			end
			tbc_pkg::MODE_STOPPED: begin
				if (b == tbc_pkg::BAND_NORMAL) begin
					code = tbc_pkg::CODE_STP_TO_NORM; exp_indicator = 1'b0;
					nxt = tbc_pkg::MODE_NORMAL;
				end else if (b == tbc_pkg::BAND_WARM || b == tbc_pkg::BAND_HOT) begin
					// stays stopped while over voltage, shown as charging
					if (high_v) exp_indicator = 1'b1;
					else begin
						code = tbc_pkg::CODE_STP_TO_RED; exp_indicator = 1'b0;
						nxt = tbc_pkg::MODE_REDUCED;
					end
				end else if (b == tbc_pkg::BAND_OVER) begin
					exp_indicator = 1'b0;
				end
			end
			default: ;
		endcase
		exp_mode = nxt;

		case (exp_mode)
			tbc_pkg::MODE_NORMAL:  cur = (s.thermal_ma <= s.normal_ma) ? s.thermal_ma
				: s.normal_ma;
			tbc_pkg::MODE_REDUCED: cur = (s.thermal_ma <= reg_reduced_cur) ? s.thermal_ma
				: reg_reduced_cur;
			default:               cur = reg_default_cur;
		endcase
		if (exp_last_current != cur) begin
			exp_last_current = cur;
			upd = 1'b1;
		end
		if (exp_last_indicator != exp_indicator) begin
			exp_last_indicator = exp_indicator;
			upd = 1'b1;
		end

		r.charge_state    = exp_mode;
		r.code            = code;
		r.update_req      = upd;
		r.charge_disable  = (exp_mode == tbc_pkg::MODE_STOPPED);
		r.drive_current   = cur;
		r.health          = (b == tbc_pkg::BAND_OVER) ? tbc_pkg::HEALTH_HOT
			: (b == tbc_pkg::BAND_FROZEN) ? tbc_pkg::HEALTH_COLD : tbc_pkg::HEALTH_GOOD;
		r.pseudo_charging = exp_indicator;
		return r;
	endfunction

	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, GapMax);
	endfunction

	// ------------------------------------------------------------------
	// Sample driver: prediction is made at the accepting edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic next_valid;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				predicted_results.push_back(charge_step(cur_sample));
				samples_taken++;
				next_valid = 1'b0;
				in_gap = draw_gap();
			end
			if (!next_valid) begin
				if (in_gap != 0) in_gap--;
				else if (sample_q.size() != 0) begin
					cur_sample = sample_q.pop_front();
					battery_temp     <= cur_sample.temp;
					battery_uv       <= cur_sample.uv;
					charger_present  <= cur_sample.present;
					charger_swapped  <= cur_sample.swapped;
					normal_limit_ma  <= cur_sample.normal_ma;
					thermal_limit_ma <= cur_sample.thermal_ma;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// ------------------------------------------------------------------
	// Register write driver; writes only arrive while the block is drained
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic       next_valid;
		reg_write_t w;
		if (arst_n) begin
			next_valid = cfg_valid;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tbc_pkg::REG_VOLT_LIMIT:  reg_volt_limit  = cfg_data;
					tbc_pkg::REG_REDUCED_CUR: reg_reduced_cur = cfg_data[tbc_pkg::CurW-1:0];
					tbc_pkg::REG_DEFAULT_CUR: reg_default_cur = cfg_data[tbc_pkg::CurW-1:0];
					default: ;   // unmapped, dropped
				endcase
				writes_taken++;
				next_valid = 1'b0;
			end
			if (!next_valid && reg_write_q.size() != 0) begin
				w = reg_write_q.pop_front();
				cfg_index <= w.idx;
				cfg_data  <= w.data;
				next_valid = 1'b1;
			end
			cfg_valid <= next_valid;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor with random back-pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		tbc_pkg::tbc_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: result with nothing pending: st=%0d code=%0d cur=%0d",
							charge_state, transition_code, drive_current_ma);
				end else begin
					want = predicted_results.pop_front();
					if (want.charge_state !== charge_state || want.code !== transition_code
						|| want.update_req !== update_req
						|| want.charge_disable !== charge_disable
						|| want.drive_current !== drive_current_ma || want.health !== health
						|| want.pseudo_charging !== pseudo_charging) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"tb: mismatch exp st=%0d code=%0d upd=%0d dis=%0d ",
								"cur=%0d hl=%0d ps=%0d | got st=%0d code=%0d upd=%0d ",
								"dis=%0d cur=%0d hl=%0d ps=%0d"},
								want.charge_state, want.code, want.update_req,
								want.charge_disable, want.drive_current, want.health,
								want.pseudo_charging, charge_state, transition_code,
								update_req, charge_disable, drive_current_ma, health,
								pseudo_charging);
					end
				end
				out_stall = draw_gap();
			end
			if (out_stall != 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic queue_sample(int t, int uv, bit present, bit swapped, int nrm, int thr);
		sample_t s;
		s.temp       = tbc_pkg::temp_t'(t);
		s.uv         = tbc_pkg::volt_t'(uv);
		s.present    = present;
		s.swapped    = swapped;
		s.normal_ma  = tbc_pkg::cur_t'(nrm);
		s.thermal_ma = tbc_pkg::cur_t'(thr);
		sample_q.push_back(s);
		samples_sent++;
	endtask

	task automatic write_reg(logic [tbc_pkg::CfgIdxW-1:0] idx, int data);
		reg_write_q.push_back('{idx, tbc_pkg::volt_t'(data)});
		writes_sent++;
	endtask

	// every sample and write taken, every result back, then a short drain
	task automatic wait_idle();
		while (samples_taken != samples_sent || writes_taken != writes_sent
			|| predicted_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		int  lim;
		int  walk_temp;
		int  t;
		int  v;
		int  nrm;
		int  thr;
		int  red;
		int  dflt;
		bit  charger;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed walk through every transition at reset register values
		queue_sample(25, 3800000, 1, 0, 1000, 4095);     // attach: back to normal
		queue_sample(46, 3900000, 1, 0, 1000, 4095);     // normal -> reduced
		queue_sample(42, 4000000, 1, 0, 1000, 4095);     // at limit, stays reduced
		queue_sample(41, 3900000, 1, 0, 1000, 4095);     // reduced -> normal
		queue_sample(53, 4000001, 1, 0, 1000, 4095);     // over voltage: stop, pseudo
		queue_sample(45, 4100000, 1, 0, 1000, 4095);     // stopped, indicator held
		queue_sample(52, 3500000, 1, 0, 1000, 4095);     // stopped -> reduced
		queue_sample(55, 4200000, 1, 0, 1000, 4095);     // reduced -> stopped, pseudo
		queue_sample(-5, 3500000, 1, 0, 1000, 4095);     // cold band leaves it alone
		queue_sample(-4, 3500000, 1, 0, 1000, 4095);     // stopped -> normal
		queue_sample(-11, 3500000, 1, 0, 1000, 4095);    // frozen: stop, cold health
		queue_sample(56, 3500000, 1, 0, 1000, 4095);     // overheat
		queue_sample(-10, 4500000, 1, 0, 1000, 4095);
		queue_sample(-128, 0, 1, 0, 1000, 4095);
		queue_sample(127, VoltMax, 1, 0, 1000, 4095);
		queue_sample(0, 3700000, 1, 1, 1000, 4095);      // swap flag restarts normal
		queue_sample(46, 3700000, 1, 0, 1000, 4095);
		queue_sample(-128, 3700000, 1, 0, 1000, 4095);   // reduced -> stopped on cold
		queue_sample(20, 3700000, 0, 0, 1000, 4095);     // detach, no restart
		queue_sample(20, 3700000, 0, 1, 1000, 4095);     // swap while detached
		queue_sample(20, 3700000, 1, 0, 0, 4095);
		queue_sample(20, 3700000, 1, 0, 4095, 0);
		queue_sample(20, 3700000, 1, 0, 4095, 4095);
		wait_idle();

		walk_temp = 20;
		charger   = 1'b1;
		nrm       = 1200;
		thr       = 2000;
		for (int ph = 0; ph < NumPhases; ph++) begin
			// first two phases take the register extremes
			if (ph == 0) begin
				lim = 0; red = 0; dflt = 0;
			end else if (ph == 1) begin
				lim = VoltMax; red = 4095; dflt = 4095;
			end else begin
				lim  = $urandom_range(3500000, 4500000);
				red  = $urandom_range(0, 4095);
				dflt = $urandom_range(0, 4095);
			end
			write_reg(tbc_pkg::REG_VOLT_LIMIT, lim);
			// upper data bits are junk for the current registers
			write_reg(tbc_pkg::REG_REDUCED_CUR, ($urandom_range(0, 2047) << tbc_pkg::CurW) | red);
			write_reg(tbc_pkg::REG_DEFAULT_CUR, ($urandom_range(0, 2047) << tbc_pkg::CurW) | dflt);
			if (ph == 2) write_reg(RegSpare, $urandom_range(0, VoltMax));
			wait_idle();

			no_idle = (ph == 3);
			repeat (RandPerPhase) begin
				// mostly a slow temperature drift, some jumps to band edges or anywhere
				if ($urandom_range(0, 9) < 8)
					t = walk_temp + int'($urandom_range(0, 8)) - 4;
				else if ($urandom_range(0, 1) == 1)
					t = int'(band_tops[$urandom_range(0, 5)]) + int'($urandom_range(0, 1));
				else
					t = int'($urandom_range(0, 255)) - 128;
				if (t < -128) t = -128;
				if (t > 127) t = 127;
				walk_temp = t;

				case ($urandom_range(0, 3))
					0, 1:    v = lim + int'($urandom_range(0, 6)) - 3;
					2:       v = $urandom_range(0, VoltMax);
					default: v = $urandom_range(3500000, 4500000);
				endcase
				if (v < 0) v = 0;
				if (v > VoltMax) v = VoltMax;

				if ($urandom_range(0, 19) == 0) charger = !charger;
				if ($urandom_range(0, 3) == 0)
					nrm = ($urandom_range(0, 3) == 0) ? 4095 * $urandom_range(0, 1)
						: $urandom_range(0, 4095);
				if ($urandom_range(0, 3) == 0)
					thr = ($urandom_range(0, 3) == 0) ? 4095 * $urandom_range(0, 1)
						: $urandom_range(0, 4095);
				queue_sample(t, v, charger, $urandom_range(0, 19) == 0, nrm, thr);
			end
			// sender holds off here until every result is back
			wait_idle();
		end

		if (mismatches == 0 && predicted_results.size() == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule
